FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// types and constants of the hex record parser
// ----------------------------------------------------------------------------
package ihex_pkg;

    // parse phase
    typedef enum logic [2:0] {
        PH_COLON = 3'd0,
        PH_LEN   = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5,
        PH_SKIP  = 3'd6
    } phase_t;

    // run state
    typedef enum logic [1:0] {
        HS_RUN  = 2'd0,
        HS_ERR  = 2'd1,
        HS_EOF  = 2'd2
    } halt_t;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_COLON = 2'd1;
    localparam logic [1:0] ERR_HEX   = 2'd2;
    localparam logic [1:0] ERR_CSUM  = 2'd3;

    // characters and record types
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] TYPE_EOF = 8'h01;

    // output payload layout
    localparam int ADDR_W  = 17;
    localparam int TDATA_W = 40;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // decode one ascii hex digit, either case
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            d.value = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            d.value = c[3:0] + 4'd9;
        else
            d.valid = 1'b0;
        return d;
    endfunction

endpackage

FILE: rtl/intel_hex_record_parser.sv
// A result item appears on the master side in the cycle after the character is taken.
// Throughput: one character per cycle; the parse state updates in a single registered step.
// The slave side stalls only while a result waits in the output register and is not taken.
// Reset (rst_n low, asynchronous): parser waits for ':', counters and sums clear,
// the output register empties; errors and end-of-file records hold until reset.
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// character-stream parser for hex records, emitting data writes and record status
// ----------------------------------------------------------------------------
module intel_hex_record_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [16:0] address, [24:17] data_byte,
                                        // [32:25] record_type, [34:33] error_code
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);
    import ihex_pkg::*;

    // parser state
    phase_t              phase_reg,   phase_next;
    halt_t               halted_reg,  halted_next;
    logic [1:0]          nib_reg,     nib_next;
    logic [15:0]         accum_reg,   accum_next;
    logic [7:0]          left_reg,    left_next;
    logic [ADDR_W-1:0]   addr_reg,    addr_next;
    logic [7:0]          sum_reg,     sum_next;
    logic [7:0]          type_reg,    type_next;

    // output register
    logic                ovalid_reg,  ovalid_next;
    logic [1:0]          okind_reg,   okind_next;
    logic [ADDR_W-1:0]   oaddr_reg,   oaddr_next;
    logic [7:0]          odata_reg,   odata_next;
    logic [7:0]          otype_reg,   otype_next;
    logic [1:0]          oerr_reg,    oerr_next;

    logic                accept;
    logic                active;
    logic [7:0]          c;
    hex_digit_t          dig;
    logic [15:0]         shifted;
    logic                field_done;
    logic [7:0]          csum;

    // handshake and shared decode
    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign active        = accept && (halted_reg == HS_RUN);
    assign c             = s_axis_tdata;
    assign dig           = hex_decode(c);
    assign shifted       = {accum_reg[11:0], dig.value};
    assign field_done    = (phase_reg == PH_ADDR) ? (nib_reg == 2'd3) : (nib_reg == 2'd1);
    assign csum          = sum_reg + shifted[7:0];

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        halted_next = halted_reg;
        nib_next    = nib_reg;
        accum_next  = accum_reg;
        left_next   = left_reg;
        addr_next   = addr_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        if (active)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (c == CH_LF)
                        phase_next = PH_COLON;
                end
                PH_COLON:
                begin
                    priority if (c == CH_CR || c == CH_LF)
                        phase_next = PH_COLON;
                    else if (c != CH_COLON)
                        halted_next = HS_ERR;
                    else
                    begin
                        phase_next = PH_LEN;
                        nib_next   = 2'd0;
                        accum_next = 16'd0;
                    end
                end
                default:
                begin
                    priority if (!dig.valid)
                        halted_next = HS_ERR;
                    else if (!field_done)
                    begin
                        nib_next   = nib_reg + 2'd1;
                        accum_next = shifted;
                    end
                    else
                    begin
                        nib_next   = 2'd0;
                        accum_next = 16'd0;
                        unique case (phase_reg)
                            PH_LEN:
                            begin
                                left_next  = shifted[7:0];
                                sum_next   = shifted[7:0];
                                phase_next = PH_ADDR;
                            end
                            PH_ADDR:
                            begin
                                addr_next  = {1'b0, shifted};
                                sum_next   = sum_reg + shifted[15:8] + shifted[7:0];
                                phase_next = PH_TYPE;
                            end
                            PH_TYPE:
                            begin
                                type_next  = shifted[7:0];
                                sum_next   = sum_reg + shifted[7:0];
                                phase_next = (left_reg == 8'd0) ? PH_CSUM : PH_DATA;
                            end
                            PH_DATA:
                            begin
                                sum_next  = sum_reg + shifted[7:0];
                                addr_next = addr_reg + {{(ADDR_W-1){1'b0}}, 1'b1};
                                left_next = left_reg - 8'd1;
                                if (left_reg == 8'd1)
                                    phase_next = PH_CSUM;
                            end
                            default:
                            begin
                                // checksum byte
                                sum_next = csum;
                                priority if (csum != 8'd0)
                                    halted_next = HS_ERR;
                                else
                                begin
                                    if (type_reg == TYPE_EOF)
                                        halted_next = HS_EOF;
                                    phase_next = PH_SKIP;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // result item
    always_comb
    begin
        ovalid_next = ovalid_reg && !m_axis_tready;
        okind_next  = okind_reg;
        oaddr_next  = oaddr_reg;
        odata_next  = odata_reg;
        otype_next  = otype_reg;
        oerr_next   = oerr_reg;
        if (active)
        begin
            logic       emit;
            logic [1:0] kind;
            logic [1:0] err;
            emit = 1'b0;
            kind = KIND_ERROR;
            err  = ERR_NONE;
            unique case (phase_reg)
                PH_SKIP:
                    emit = 1'b0;
                PH_COLON:
                begin
                    if (c != CH_CR && c != CH_LF && c != CH_COLON)
                    begin
                        emit = 1'b1;
                        err  = ERR_COLON;
                    end
                end
                default:
                begin
                    priority if (!dig.valid)
                    begin
                        emit = 1'b1;
                        err  = ERR_HEX;
                    end
                    else if (field_done && phase_reg == PH_DATA)
                    begin
                        emit = 1'b1;
                        kind = KIND_WRITE;
                    end
                    else if (field_done && phase_reg == PH_CSUM)
                    begin
                        emit = 1'b1;
                        if (csum != 8'd0)
                            err = ERR_CSUM;
                        else
                            kind = KIND_DONE;
                    end
                    else
                        emit = 1'b0;
                end
            endcase
            if (emit)
            begin
                ovalid_next = 1'b1;
                okind_next  = kind;
                oerr_next   = err;
                oaddr_next  = (kind == KIND_WRITE) ? addr_reg : '0;
                odata_next  = (kind == KIND_WRITE) ? shifted[7:0] : 8'd0;
                otype_next  = (kind == KIND_DONE) ? type_reg : 8'd0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_COLON;
            halted_reg <= HS_RUN;
            nib_reg    <= 2'd0;
            accum_reg  <= 16'd0;
            left_reg   <= 8'd0;
            addr_reg   <= '0;
            sum_reg    <= 8'd0;
            type_reg   <= 8'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            halted_reg <= halted_next;
            nib_reg    <= nib_next;
            accum_reg  <= accum_next;
            left_reg   <= left_next;
            addr_reg   <= addr_next;
            sum_reg    <= sum_next;
            type_reg   <= type_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        okind_reg <= okind_next;
        oaddr_reg <= oaddr_next;
        odata_reg <= odata_next;
        otype_reg <= otype_next;
        oerr_reg  <= oerr_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tdata  = {{(TDATA_W-ADDR_W-18){1'b0}}, oerr_reg, otype_reg, odata_reg,
                            oaddr_reg};

endmodule

FILE: rtl/ihex_checker.sv
// ----------------------------------------------------------------------------
// ihex_checker
// port-level checks of the hex record parser, bound into the parser module
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ihex_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import ihex_pkg::*;

    logic err_taken;
    logic in_taken;

    assign err_taken = m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_ERROR);
    assign in_taken  = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'd0);

    // a stalled result item holds
    `ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an error item always carries a code and nothing else
    `ASSERT_ALWAYS(a_err_code, !(m_axis_tvalid && m_axis_tuser == KIND_ERROR) || (m_axis_tdata[34:33] != ERR_NONE && m_axis_tdata[32:0] == 33'd0))

    // a data write carries no record type and no error code
    `ASSERT_ALWAYS(a_write_clean, !(m_axis_tvalid && m_axis_tuser == KIND_WRITE) || m_axis_tdata[34:25] == 10'd0)

    // once an error has been delivered, the output goes empty
    `ASSERT_NEXT(a_halt, err_taken || (in_taken && !m_axis_tvalid && $past(err_taken)), !m_axis_tvalid)

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
